@@ sv/pas_pkg.sv @@
`default_nettype none

package pas_pkg;

	// table geometry
	localparam int MAX_USERS = 64;
	localparam int SLOT_W    = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;

	// field widths
	localparam int OWNER_W = 31;
	localparam int ADDR_W  = 64;
	localparam int CNT_W   = 7;
	localparam int IPV4_W  = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// commands
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_COUNT  = 2'd2;

	// add outcomes
	localparam logic [1:0] ADD_FREE    = 2'd0;
	localparam logic [1:0] ADD_REPLACE = 2'd1;
	localparam logic [1:0] ADD_EVICT   = 2'd2;
	localparam logic [1:0] ADD_NONE    = 2'd3;

	// one stored slot
	typedef struct packed {
		logic [OWNER_W-1:0] owner;
		logic               family;
		logic [ADDR_W-1:0]  addr_high;
		logic [ADDR_W-1:0]  addr_low;
	} slot_t;

	localparam int ENTRY_W = $bits(slot_t);

	// map a position in age order onto a physical slot of the ring
	function automatic logic [SLOT_W-1:0] slot_phys(input logic [SLOT_W-1:0] base,
			input logic [SLOT_W-1:0] pos);
		logic [SLOT_W:0] sum;
		sum = {1'b0, base} + {1'b0, pos};
		if (sum >= (SLOT_W+1)'(MAX_USERS)) begin
			sum = sum - (SLOT_W+1)'(MAX_USERS);
		end
		return sum[SLOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/pas_req_if.sv @@
`default_nettype none

interface pas_req_if
	import pas_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [OWNER_W-1:0] owner_id;
	logic               addr_family;
	logic [ADDR_W-1:0]  addr_high;
	logic [ADDR_W-1:0]  addr_low;

	modport source (
		output valid, command, owner_id, addr_family, addr_high, addr_low,
		input  ready
	);

	modport sink (
		input  valid, command, owner_id, addr_family, addr_high, addr_low,
		output ready
	);
endinterface

`default_nettype wire

@@ sv/pas_rsp_if.sv @@
`default_nettype none

interface pas_rsp_if
	import pas_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] match_count;
	logic [1:0]       add_outcome;
	logic             delete_hit;

	modport source (
		output valid, match_count, add_outcome, delete_hit,
		input  ready
	);

	modport sink (
		input  valid, match_count, add_outcome, delete_hit,
		output ready
	);
endinterface

`default_nettype wire

@@ sv/pas_ram.sv @@
`default_nettype none

module pas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/per_address_session_table.sv @@
// Session table of MAX_USERS slots held in one synchronous RAM, one item at a time.
// An add or count reads every slot in age order, one per cycle through the single
// read port; an add that finds a free slot and a delete that finds its owner stop
// at that slot. A delete of owner zero and the unused command skip the scan.
// Eviction is a ring pointer step, not a copy. Free/occupied bits sit in
// flip-flops cleared by reset, so no clearing pass is needed. A new item is taken
// while a result still waits at the output.
`default_nettype none

module per_address_session_table
	import pas_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	pas_req_if.sink    req,
	pas_rsp_if.source  rsp
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_WRITE = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	// item fields
	logic [1:0]         cmd_q;
	logic [OWNER_W-1:0] own_q;
	logic               fam_q;
	logic [ADDR_W-1:0]  hi_q;
	logic [ADDR_W-1:0]  lo_q;

	// table control
	logic [MAX_USERS-1:0] valid_q;
	logic [SLOT_W-1:0]    base_q;

	// scan control
	logic [SLOT_W-1:0] iss_q;
	logic              iss_done_q;
	logic              chk_s1;
	logic              last_s1;
	logic [SLOT_W-1:0] phys_s1;
	logic              hit_q;
	logic [SLOT_W-1:0] tphys_q;
	logic              mfound_q;
	logic [SLOT_W-1:0] mphys_q;
	logic [CNT_W-1:0]  cnt_q;

	// pending result and output register
	logic [CNT_W-1:0] res_count_q;
	logic [1:0]       res_outcome_q;
	logic             res_hit_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] out_count_q;
	logic [1:0]       out_outcome_q;
	logic             out_hit_q;

	// memory ports
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	slot_t             ram_wdata;
	logic              ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	slot_t rd_slot;
	logic  occ;
	logic  amatch;
	logic  stop;
	logic  done_scan;
	logic  in_xfer;
	logic  out_free;

	pas_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_USERS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// compare the slot that came back from memory
	always_comb begin
		rd_slot = slot_t'(ram_rdata);
		occ     = valid_q[phys_s1] && (rd_slot.owner != '0);
		if (rd_slot.family != fam_q) begin
			amatch = 1'b0;
		end else if (fam_q) begin
			amatch = (rd_slot.addr_high == hi_q) && (rd_slot.addr_low == lo_q);
		end else begin
			amatch = rd_slot.addr_low[IPV4_W-1:0] == lo_q[IPV4_W-1:0];
		end
		stop = chk_s1 && (((cmd_q == CMD_ADD) && !occ)
			|| ((cmd_q == CMD_DELETE) && occ && (rd_slot.owner == own_q)));
		done_scan = chk_s1 && (stop || last_s1);
	end

	// issue reads in age order, write back once the scan has settled
	always_comb begin
		ram_re    = (state_q == S_SCAN) && !iss_done_q && !done_scan;
		ram_raddr = slot_phys(base_q, iss_q);
		ram_we    = (state_q == S_WRITE) && (cmd_q == CMD_ADD);
		if (hit_q) begin
			ram_waddr = tphys_q;
		end else if (mfound_q) begin
			ram_waddr = mphys_q;
		end else begin
			ram_waddr = base_q;
		end
		ram_wdata = '{owner: own_q, family: fam_q, addr_high: hi_q, addr_low: lo_q};
	end

	assign in_xfer  = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.match_count = out_count_q;
	assign rsp.add_outcome = out_outcome_q;
	assign rsp.delete_hit  = out_hit_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			base_q      <= '0;
			iss_q       <= '0;
			iss_done_q  <= 1'b0;
			chk_s1      <= 1'b0;
			hit_q       <= 1'b0;
			mfound_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			chk_s1 <= ram_re;
			// offer a settled result, drop it once transferred
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						iss_q      <= '0;
						iss_done_q <= 1'b0;
						hit_q      <= 1'b0;
						mfound_q   <= 1'b0;
						cnt_q      <= '0;
						if ((req.command == CMD_ADD) || (req.command == CMD_COUNT)
							|| ((req.command == CMD_DELETE) && (req.owner_id != '0))) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					// advance the read pointer
					if (ram_re) begin
						iss_q <= iss_q + 1'b1;
						if (iss_q == SLOT_W'(MAX_USERS - 1)) begin
							iss_done_q <= 1'b1;
						end
					end
					// accumulate what the returned slot shows
					if (chk_s1) begin
						if ((cmd_q == CMD_COUNT) && occ && amatch && (cnt_q != CNT_MAX)) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if ((cmd_q == CMD_ADD) && occ && amatch && !mfound_q) begin
							mfound_q <= 1'b1;
						end
						if (stop) begin
							hit_q <= 1'b1;
						end
					end
					if (done_scan) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					// mark the written slot, free a deleted one, step the ring on eviction
					if (cmd_q == CMD_ADD) begin
						valid_q[ram_waddr] <= 1'b1;
						if (!hit_q && !mfound_q) begin
							if (base_q == SLOT_W'(MAX_USERS - 1)) begin
								base_q <= '0;
							end else begin
								base_q <= base_q + 1'b1;
							end
						end
					end else if ((cmd_q == CMD_DELETE) && hit_q) begin
						valid_q[tphys_q] <= 1'b0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		phys_s1 <= ram_raddr;
		last_s1 <= (iss_q == SLOT_W'(MAX_USERS - 1));
		if (in_xfer) begin
			cmd_q         <= req.command;
			own_q         <= req.owner_id;
			fam_q         <= req.addr_family;
			hi_q          <= req.addr_high;
			lo_q          <= req.addr_low;
			res_count_q   <= '0;
			res_hit_q     <= 1'b0;
			res_outcome_q <= ADD_NONE;
		end
		if ((state_q == S_SCAN) && chk_s1) begin
			if (stop) begin
				tphys_q <= phys_s1;
			end
			if ((cmd_q == CMD_ADD) && occ && amatch && !mfound_q) begin
				mphys_q <= phys_s1;
			end
		end
		// settle the result
		if (state_q == S_WRITE) begin
			case (cmd_q)
				CMD_ADD: begin
					if (hit_q) begin
						res_outcome_q <= ADD_FREE;
					end else if (mfound_q) begin
						res_outcome_q <= ADD_REPLACE;
					end else begin
						res_outcome_q <= ADD_EVICT;
					end
				end
				CMD_DELETE: res_hit_q   <= hit_q;
				CMD_COUNT:  res_count_q <= cnt_q;
				default:    res_outcome_q <= ADD_NONE;
			endcase
		end
		// hand the result to the output register
		if ((state_q == S_DONE) && out_free) begin
			out_count_q   <= res_count_q;
			out_outcome_q <= res_outcome_q;
			out_hit_q     <= res_hit_q;
		end
	end

endmodule

`default_nettype wire

@@ sv/pas_checker.sv @@
`default_nettype none

module pas_checker
	import pas_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_ready,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire logic [CNT_W-1:0] match_count,
	input wire logic [1:0]       add_outcome,
	input wire logic             delete_hit
);

	// one item at a time: the block is busy right after a transfer in
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input taken on two consecutive edges");

	// a result stays offered until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn before transfer");

	// a delete hit carries no add outcome and no count
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && delete_hit |-> (add_outcome == ADD_NONE) && (match_count == '0))
		else $error("delete hit mixed with other results");

	// an add result carries no count, and a count never exceeds the table
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((add_outcome == ADD_NONE) || (match_count == '0))
			&& (match_count <= CNT_W'(MAX_USERS)))
		else $error("count inconsistent with outcome or table size");

endmodule

bind per_address_session_table pas_checker u_pas_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.match_count (rsp.match_count),
	.add_outcome (rsp.add_outcome),
	.delete_hit  (rsp.delete_hit)
);

`default_nettype wire
